// ===== rtl/rps_pkg.sv =====
// ----------------------------------------------------------------------------
// rps_pkg: shared types and constants of the recurring poll scheduler
// Request and result structs, the slot record and the fixed codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

    localparam int MAX_RESULTS   = 16;
    localparam int FIRE_W        = $clog2(MAX_RESULTS + 1);
    localparam int MIN_PAYLOAD   = 10;
    localparam int FIXED_PAYLOAD = 11;
    localparam int SLOT_OUT_W    = 4;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BAD  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    typedef struct packed {
        logic        cmd;
        logic [15:0] req_id;
        logic [7:0]  port;
        logic [7:0]  dev_addr;
        logic [15:0] period_ms;
        logic [15:0] count;
        logic [7:0]  rd_bytes;
        logic [7:0]  ptr_bytes;
        logic [7:0]  tail_bytes;
        logic [15:0] payload_len;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic                  kind;
        logic [1:0]            status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [15:0]           job_id;
        logic [15:0]           seq;
        logic [2:0]            bus_port;
        logic [7:0]            bus_addr;
        logic [6:0]            rd_len;
        logic [5:0]            wr_len;
        logic [4:0]            pst_len;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic [15:0] id;
        logic [2:0]  port;
        logic [7:0]  addr;
        logic [15:0] interval;
        logic [7:0]  rd_len;
        logic [7:0]  wr_len;
        logic [7:0]  pst_len;
        logic [15:0] seq;
        logic [15:0] remaining;
        logic [31:0] next_fire;
    } slot_rec_t;

endpackage

`default_nettype wire

// ===== rtl/rps_slot_mem.sv =====
// ----------------------------------------------------------------------------
// rps_slot_mem: slot record memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_slot_mem
    import rps_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire slot_rec_t        wr_data,
    input  wire logic [IDX_W-1:0] rd_addr,
    output slot_rec_t             rd_data
);

    slot_rec_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/recurring_poll_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// recurring_poll_scheduler_core: table of recurring poll jobs
// Requests set, override or cancel a job; a tick fires up to MAX_RESULTS due
// jobs in slot order, advancing seq, remaining count and next fire time.
// ----------------------------------------------------------------------------
//  channel  ports                    direction  moves
//  s_       s_valid/s_ready/s_data   in         request or tick (in_item_t)
//  m_       m_valid/m_ready/m_data   out        ack or firing (out_item_t)
//
//  The sequencer visits one slot per cycle, unless the result channel stalls,
//  through the single read port of the slot record memory. s_ready is low
//  while an item is at work. Reset clears all active bits at once; records
//  need no reset. A stalled result channel holds the walk on the next due
//  slot.
// ----------------------------------------------------------------------------
`default_nettype none

module recurring_poll_scheduler_core
    import rps_pkg::*;
#(
    parameter int TABLE_SLOTS   = 16,
    parameter int NUM_BUS_PORTS = 8,
    parameter int MAX_READ_LEN  = 64,
    parameter int MAX_PTR_LEN   = 32,
    parameter int MAX_POST_LEN  = 16
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_REQ_WALK  = 3'd1;
    localparam logic [2:0] ST_REQ_DONE  = 3'd2;
    localparam logic [2:0] ST_TICK_WALK = 3'd3;
    localparam logic [2:0] ST_TICK_DONE = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    in_item_t               item_reg, item_next;
    logic                   bad_reg, bad_next;
    logic                   match_found_reg, match_found_next;
    logic [IDX_W-1:0]       match_idx_reg, match_idx_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [FIRE_W-1:0]      fired_reg, fired_next;
    logic [TABLE_SLOTS-1:0] active_reg, active_next;
    out_item_t              out_reg;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;

    logic             load_out;
    out_item_t        load_data;
    logic             out_free;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_rec_t        wr_data;
    slot_rec_t        rd_data;
    slot_rec_t        upd_rec;
    out_item_t        fire_item;
    out_item_t        ack_item;
    logic [IDX_W-1:0] cur_idx;
    logic             idx_in_range;
    logic             cur_active;
    logic [31:0]      due_diff;
    logic             cur_due;
    logic [15:0]      rem_dec;
    logic             req_bad;
    logic [16:0]      len_sum;
    logic [1:0]       ack_status;
    logic [IDX_W+SLOT_OUT_W-1:0] slot_wide;

    rps_slot_mem #(
        .DEPTH (TABLE_SLOTS),
        .IDX_W (IDX_W)
    ) u_slot_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (idx_next[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !out_valid_reg || m_ready;

    // request parameter check on the incoming item
    always_comb begin
        len_sum = 17'(FIXED_PAYLOAD) + {9'd0, s_data.ptr_bytes}
                + {9'd0, s_data.tail_bytes};
        req_bad = (s_data.payload_len < 16'(MIN_PAYLOAD))
               || ({1'b0, s_data.port} >= 9'(NUM_BUS_PORTS))
               || (s_data.rd_bytes > 8'(MAX_READ_LEN))
               || (s_data.ptr_bytes > 8'(MAX_PTR_LEN))
               || (s_data.tail_bytes > 8'(MAX_POST_LEN))
               || ({1'b0, s_data.payload_len} != len_sum);
    end

    // shared slot unit: due test and record advance
    always_comb begin
        cur_idx      = idx_reg[IDX_W-1:0];
        idx_in_range = (idx_reg < CNT_W'(TABLE_SLOTS));
        cur_active   = idx_in_range ? active_reg[cur_idx] : 1'b0;
        due_diff     = item_reg.now_ms - rd_data.next_fire;
        cur_due      = !due_diff[31];
        rem_dec      = rd_data.remaining - 16'd1;

        upd_rec           = rd_data;
        upd_rec.seq       = rd_data.seq + 16'd1;
        upd_rec.remaining = rem_dec;
        upd_rec.next_fire = rd_data.next_fire + {16'd0, rd_data.interval};

        slot_wide          = {{SLOT_OUT_W{1'b0}}, cur_idx};
        fire_item          = '0;
        fire_item.kind     = KIND_FIRE;
        fire_item.status   = STATUS_OK;
        fire_item.slot     = slot_wide[SLOT_OUT_W-1:0];
        fire_item.job_id   = rd_data.id;
        fire_item.seq      = rd_data.seq;
        fire_item.bus_port = rd_data.port;
        fire_item.bus_addr = rd_data.addr;
        fire_item.rd_len   = rd_data.rd_len[6:0];
        fire_item.wr_len   = rd_data.wr_len[5:0];
        fire_item.pst_len  = rd_data.pst_len[4:0];
        fire_item.last     = 1'b0;
    end

    always_comb begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        item_next        = item_reg;
        bad_next         = bad_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        fired_next       = fired_reg;
        active_next      = active_reg;
        pend_next        = pend_reg;
        pend_valid_next  = pend_valid_reg;
        load_out         = 1'b0;
        load_data        = pend_reg;
        wr_en            = 1'b0;
        wr_addr          = cur_idx;
        wr_data          = upd_rec;
        ack_status       = STATUS_OK;

        ack_item        = '0;
        ack_item.kind   = KIND_ACK;
        ack_item.job_id = item_reg.req_id;
        ack_item.last   = 1'b1;

        case (state_reg)
            ST_IDLE: begin
                idx_next = '0;
                if (s_valid) begin
                    item_next        = s_data;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    fired_next       = '0;
                    bad_next         = req_bad;
                    if (s_data.cmd == CMD_TICK) begin
                        state_next = ST_TICK_WALK;
                    end else if (req_bad) begin
                        state_next = ST_REQ_DONE;
                    end else begin
                        state_next = ST_REQ_WALK;
                    end
                end
            end

            ST_REQ_WALK: begin
                if (!idx_in_range) begin
                    state_next = ST_REQ_DONE;
                end else if (cur_active && (rd_data.id == item_reg.req_id)) begin
                    match_found_next = 1'b1;
                    match_idx_next   = cur_idx;
                    state_next       = ST_REQ_DONE;
                end else begin
                    if (!cur_active && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = cur_idx;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_REQ_DONE: begin
                if (out_free) begin
                    if (bad_reg) begin
                        ack_status = STATUS_BAD;
                    end else if (item_reg.count == 16'd0) begin
                        if (match_found_reg) begin
                            active_next[match_idx_reg] = 1'b0;
                        end
                    end else if (match_found_reg || free_found_reg) begin
                        wr_en             = 1'b1;
                        wr_addr           = match_found_reg ? match_idx_reg : free_idx_reg;
                        wr_data.id        = item_reg.req_id;
                        wr_data.port      = item_reg.port[2:0];
                        wr_data.addr      = item_reg.dev_addr;
                        wr_data.interval  = item_reg.period_ms;
                        wr_data.rd_len    = item_reg.rd_bytes;
                        wr_data.wr_len    = item_reg.ptr_bytes;
                        wr_data.pst_len   = item_reg.tail_bytes;
                        wr_data.seq       = 16'd0;
                        wr_data.remaining = item_reg.count;
                        wr_data.next_fire = item_reg.now_ms;
                        active_next[wr_addr] = 1'b1;
                    end else begin
                        ack_status = STATUS_FULL;
                    end
                    ack_item.status = ack_status;
                    load_out        = 1'b1;
                    load_data       = ack_item;
                    state_next      = ST_IDLE;
                end
            end

            ST_TICK_WALK: begin
                if (!idx_in_range || (fired_reg == FIRE_W'(MAX_RESULTS))) begin
                    state_next = ST_TICK_DONE;
                end else if (cur_active && cur_due) begin
                    // hold on this slot until the previous firing can move on
                    if (!pend_valid_reg || out_free) begin
                        wr_en           = 1'b1;
                        wr_addr         = cur_idx;
                        wr_data         = upd_rec;
                        if (rem_dec == 16'd0) begin
                            active_next[cur_idx] = 1'b0;
                        end
                        load_out        = pend_valid_reg;
                        load_data       = pend_reg;
                        pend_next       = fire_item;
                        pend_valid_next = 1'b1;
                        fired_next      = fired_reg + FIRE_W'(1);
                        idx_next        = idx_reg + CNT_W'(1);
                    end
                end else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end

            ST_TICK_DONE: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    load_out        = 1'b1;
                    load_data       = pend_reg;
                    load_data.last  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            active_reg     <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            fired_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
            fired_reg      <= fired_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg        <= item_next;
        bad_reg         <= bad_next;
        match_found_reg <= match_found_next;
        match_idx_reg   <= match_idx_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        pend_reg        <= pend_next;
        if (load_out) begin
            out_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for recurring_poll_scheduler_core
// Drives requests and ticks through a bursty valid/ready source, keeps its own
// copy of the job table to work out every acknowledge and firing, and checks
// each result against the oldest awaited one under a stalling result sink.
// ----------------------------------------------------------------------------

module testbench;
    import rps_pkg::*;

    localparam int NUM_SLOTS    = 16;
    localparam int BUS_PORTS    = 8;
    localparam int MAX_RD       = 64;
    localparam int MAX_WR       = 32;
    localparam int MAX_PST      = 16;
    localparam int ID_POOL      = 20;
    localparam int RANDOM_ITEMS = 272;
    localparam int DRAIN_TAIL   = 64;
    localparam int IDLE_LIMIT   = 4000;
    localparam logic [31:0] T0  = 32'hFFFF_FFF0;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // scheduler state as the bench sees it
    slot_rec_t   job_table [NUM_SLOTS];
    logic        job_live  [NUM_SLOTS];
    out_item_t   awaited_results [$];
    logic [15:0] id_pool [ID_POOL];
    logic [31:0] clock_ms;

    int          fail_count  = 0;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    logic [9:0]  rx_cycle    = '0;

    recurring_poll_scheduler_core #(
        .TABLE_SLOTS   (NUM_SLOTS),
        .NUM_BUS_PORTS (BUS_PORTS),
        .MAX_READ_LEN  (MAX_RD),
        .MAX_PTR_LEN   (MAX_WR),
        .MAX_POST_LEN  (MAX_PST)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // job table prediction
    // ------------------------------------------------------------------
    function automatic logic [1:0] apply_request(in_item_t it);
        int wl;
        int pl;
        int len;
        int hit;
        int spare;
        wl    = it.ptr_bytes;
        pl    = it.tail_bytes;
        len   = it.payload_len;
        hit   = -1;
        spare = -1;
        if (len < MIN_PAYLOAD || len < FIXED_PAYLOAD + wl)
            return STATUS_BAD;
        if (it.port >= BUS_PORTS || it.rd_bytes > MAX_RD || wl > MAX_WR ||
            pl > MAX_PST || len != FIXED_PAYLOAD + wl + pl)
            return STATUS_BAD;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (job_live[i] && job_table[i].id == it.req_id) begin
                hit = i;
                break;
            end
            if (!job_live[i] && spare < 0)
                spare = i;
        end
        if (it.count == 16'd0) begin
            if (hit >= 0)
                job_live[hit] = 1'b0;
            return STATUS_OK;
        end
        if (hit < 0)
            hit = spare;
        if (hit < 0)
            return STATUS_FULL;
        job_live[hit]            = 1'b1;
        job_table[hit].id        = it.req_id;
        job_table[hit].port      = it.port[2:0];
        job_table[hit].addr      = it.dev_addr;
        job_table[hit].interval  = it.period_ms;
        job_table[hit].rd_len    = it.rd_bytes;
        job_table[hit].wr_len    = it.ptr_bytes;
        job_table[hit].pst_len   = it.tail_bytes;
        job_table[hit].seq       = 16'd0;
        job_table[hit].remaining = it.count;
        job_table[hit].next_fire = it.now_ms;
        return STATUS_OK;
    endfunction

    task automatic predict_item(input in_item_t it);
        out_item_t   r;
        logic [31:0] lag;
        int          n;
        if (it.cmd == CMD_REQUEST) begin
            r        = '0;
            r.kind   = KIND_ACK;
            r.status = apply_request(it);
            r.job_id = it.req_id;
            r.last   = 1'b1;
            awaited_results.push_back(r);
        end else begin
            n = 0;
            for (int i = 0; i < NUM_SLOTS && n < MAX_RESULTS; i++) begin
                lag = it.now_ms - job_table[i].next_fire;
                // due once the signed distance to the fire time is not negative
                if (job_live[i] && !lag[31]) begin
                    r          = '0;
                    r.kind     = KIND_FIRE;
                    r.status   = STATUS_OK;
                    r.slot     = SLOT_OUT_W'(i);
                    r.job_id   = job_table[i].id;
                    r.seq      = job_table[i].seq;
                    r.bus_port = job_table[i].port;
                    r.bus_addr = job_table[i].addr;
                    r.rd_len   = job_table[i].rd_len[6:0];
                    r.wr_len   = job_table[i].wr_len[5:0];
                    r.pst_len  = job_table[i].pst_len[4:0];
                    awaited_results.push_back(r);
                    n++;
                    job_table[i].seq       = job_table[i].seq + 16'd1;
                    job_table[i].remaining = job_table[i].remaining - 16'd1;
                    job_table[i].next_fire = job_table[i].next_fire +
                                             32'(job_table[i].interval);
                    if (job_table[i].remaining == 16'd0)
                        job_live[i] = 1'b0;
                end
            end
            if (n > 0)
                awaited_results[awaited_results.size() - 1].last = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic in_item_t random_fields(logic cmd);
        in_item_t it;
        it.cmd         = cmd;
        it.req_id      = 16'($urandom);
        it.port        = 8'($urandom);
        it.dev_addr    = 8'($urandom);
        it.period_ms   = 16'($urandom);
        it.count       = 16'($urandom);
        it.rd_bytes    = 8'($urandom);
        it.ptr_bytes   = 8'($urandom);
        it.tail_bytes  = 8'($urandom);
        it.payload_len = 16'($urandom);
        it.now_ms      = $urandom;
        return it;
    endfunction

    function automatic in_item_t make_tick(logic [31:0] now);
        in_item_t it;
        it        = random_fields(CMD_TICK);
        it.now_ms = now;
        return it;
    endfunction

    function automatic in_item_t make_req(logic [15:0] id, logic [7:0] port,
                                          logic [7:0] addr, logic [15:0] interval,
                                          logic [15:0] count, logic [7:0] rl,
                                          logic [7:0] wl, logic [7:0] pl,
                                          logic [15:0] len, logic [31:0] now);
        in_item_t it;
        it.cmd         = CMD_REQUEST;
        it.req_id      = id;
        it.port        = port;
        it.dev_addr    = addr;
        it.period_ms   = interval;
        it.count       = count;
        it.rd_bytes    = rl;
        it.ptr_bytes   = wl;
        it.tail_bytes  = pl;
        it.payload_len = len;
        it.now_ms      = now;
        return it;
    endfunction

    function automatic in_item_t rand_request(logic [31:0] base_ms);
        in_item_t it;
        int       flavor;
        int       breakage;
        flavor         = $urandom_range(0, 19);
        breakage       = $urandom_range(0, 24);
        it.cmd         = CMD_REQUEST;
        it.req_id      = id_pool[$urandom_range(0, ID_POOL - 1)];
        it.port        = 8'($urandom_range(0, BUS_PORTS - 1));
        it.dev_addr    = 8'($urandom);
        it.period_ms   = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 12));
        it.count       = (flavor < 3) ? 16'd0 :
                         (flavor < 5) ? 16'($urandom) : 16'($urandom_range(1, 5));
        it.rd_bytes    = 8'($urandom_range(0, MAX_RD));
        it.ptr_bytes   = 8'($urandom_range(0, MAX_WR));
        it.tail_bytes  = 8'($urandom_range(0, MAX_PST));
        it.now_ms      = ($urandom_range(0, 19) == 0) ? $urandom
                                                      : base_ms + $urandom_range(0, 6);
        // break one rule in about a quarter of the requests
        if (breakage == 0) it.port       = 8'($urandom_range(BUS_PORTS, 255));
        if (breakage == 1) it.rd_bytes   = 8'($urandom_range(MAX_RD + 1, 255));
        if (breakage == 2) it.ptr_bytes  = 8'($urandom_range(MAX_WR + 1, 255));
        if (breakage == 3) it.tail_bytes = 8'($urandom_range(MAX_PST + 1, 255));
        it.payload_len = 16'(FIXED_PAYLOAD + it.ptr_bytes + it.tail_bytes);
        if (breakage == 4) it.payload_len = 16'($urandom);
        if (breakage == 5) it = random_fields(CMD_REQUEST);
        return it;
    endfunction

    // ------------------------------------------------------------------
    // request source
    // ------------------------------------------------------------------
    task automatic send_item(input in_item_t it);
        s_data <= it;
        if (!s_valid)
            s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_item(it);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 20);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    endtask

    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // result sink and checker
    // ------------------------------------------------------------------
    function automatic string result_text(out_item_t r);
        return {$sformatf("kind=%0d st=%0d slot=%0d id=%h seq=%0d ",
                          r.kind, r.status, r.slot, r.job_id, r.seq),
                $sformatf("port=%0d addr=%h rd=%0d wr=%0d pst=%0d last=%0d",
                          r.bus_port, r.bus_addr, r.rd_len, r.wr_len,
                          r.pst_len, r.last)};
    endfunction

    function automatic string field_diffs(out_item_t e, out_item_t g);
        string s;
        s = "";
        if (e.kind     !== g.kind)     s = {s, " kind"};
        if (e.status   !== g.status)   s = {s, " status"};
        if (e.slot     !== g.slot)     s = {s, " slot"};
        if (e.job_id   !== g.job_id)   s = {s, " job_id"};
        if (e.seq      !== g.seq)      s = {s, " seq"};
        if (e.bus_port !== g.bus_port) s = {s, " bus_port"};
        if (e.bus_addr !== g.bus_addr) s = {s, " bus_addr"};
        if (e.rd_len   !== g.rd_len)   s = {s, " rd_len"};
        if (e.wr_len   !== g.wr_len)   s = {s, " wr_len"};
        if (e.pst_len  !== g.pst_len)  s = {s, " pst_len"};
        if (e.last     !== g.last)     s = {s, " last"};
        return s;
    endfunction

    always @(posedge aclk) begin : result_sink
        out_item_t want;
        string     diffs;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: %s", result_text(m_data));
            end else begin
                want  = awaited_results.pop_front();
                diffs = field_diffs(want, m_data);
                if (diffs != "") begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch in%s\n  expected %s\n  actual   %s",
                                 diffs, result_text(want), result_text(m_data));
                end
            end
        end
        // stall pattern shifts with bits 9:7 of rx_cycle
        rx_cycle <= rx_cycle + 10'd1;
        case (rx_cycle[9:7])
            3'd0, 3'd1: m_ready <= 1'b1;
            3'd2, 3'd3: m_ready <= 1'($urandom_range(0, 1));
            3'd4:       m_ready <= (rx_cycle[1:0] == 2'd0);
            3'd5:       m_ready <= (rx_cycle[3:0] >= 4'd10);
            default:    m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_empty_tick();
        send_item(make_tick(T0));
        hold_until_drained();
    endtask

    task automatic test_bad_requests();
        send_item(make_req(16'hA5A5, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                           8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_req(16'h0001, 8'd8, 8'h11, 16'd1, 16'd1,
                           8'd1, 8'd1, 8'd1, 16'd13, T0));
        send_item(make_req(16'h0002, 8'd1, 8'h22, 16'd1, 16'd1,
                           8'd65, 8'd0, 8'd0, 16'd11, T0));
        // too short for the fixed header
        send_item(make_req(16'h0003, 8'd2, 8'h33, 16'd1, 16'd1,
                           8'd0, 8'd0, 8'd0, 16'd10, T0));
        hold_until_drained();
    endtask

    task automatic test_set_fire_override();
        send_item(make_req(16'h0000, 8'd0, 8'h00, 16'd0, 16'd1,
                           8'd0, 8'd0, 8'd0, 16'd11, T0));
        send_item(make_req(16'hFFFF, 8'd7, 8'hFF, 16'hFFFF, 16'hFFFF,
                           8'd64, 8'd32, 8'd16, 16'd59, T0));
        send_item(make_tick(T0));
        send_item(make_req(16'hFFFF, 8'd3, 8'h5A, 16'd16, 16'd2,
                           8'd10, 8'd4, 8'd2, 16'd17, T0 + 32'd16));
        send_item(make_req(16'h1234, 8'd4, 8'h01, 16'd5, 16'd0,
                           8'd8, 8'd0, 8'd0, 16'd11, T0));
        hold_until_drained();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < NUM_SLOTS - 1; i++)
            send_item(make_req(16'h0100 + 16'(i), 8'(i % BUS_PORTS), 8'(i * 17),
                               16'd1, 16'd3, 8'(i), 8'(i), 8'(i),
                               16'(FIXED_PAYLOAD + 2 * i), T0 + 32'd32));
        send_item(make_req(16'h0200, 8'd5, 8'h77, 16'd1, 16'd1,
                           8'd1, 8'd1, 8'd1, 16'd13, T0));
        // every slot due at once, across the 32-bit wrap
        send_item(make_tick(T0 + 32'd32));
        send_item(make_req(16'hFFFF, 8'd0, 8'h00, 16'd0, 16'd0,
                           8'd0, 8'd0, 8'd0, 16'd11, T0));
        hold_until_drained();
    endtask

    task automatic test_random_traffic();
        in_item_t it;
        for (int k = 0; k < ID_POOL; k++)
            id_pool[k] = 16'($urandom);
        clock_ms = T0 + 32'd33;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2)
                hold_until_drained();
            if ($urandom_range(0, 99) < 45) begin
                it = rand_request(clock_ms);
            end else begin
                if ($urandom_range(0, 24) == 0)
                    clock_ms = clock_ms + $urandom_range(0, 32'h7FFF_FFFF);
                else
                    clock_ms = clock_ms + $urandom_range(0, 4);
                it = make_tick(clock_ms);
                if ($urandom_range(0, 29) == 0)
                    it.now_ms = $urandom;
            end
            send_item(it);
        end
        hold_until_drained();
    endtask

    initial begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            job_live[i]  = 1'b0;
            job_table[i] = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_tick();
        test_bad_requests();
        test_set_fire_override();
        test_table_full();
        test_random_traffic();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rps_pkg.sv
rtl/rps_slot_mem.sv
rtl/recurring_poll_scheduler_core.sv
tb/testbench.sv
